[rtl/lhc_pkg.sv]
// Package: shared types, widths and codes for the LRU handle cache with pinning.
`default_nettype none

package lhc_pkg;

  localparam int NUM_OBJECTS_DEF = 64;
  localparam int PIN_BITS_DEF    = 8;

  localparam int REQ_W     = 2;
  localparam int ID_W      = 6;
  localparam int OUTC_W    = 3;
  localparam int PIN_OUT_W = 8;
  localparam int CNT_W     = 7;
  localparam int CAP_W     = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DROP    = 2'd2;

  localparam logic [OUTC_W-1:0] OUT_EVICTED  = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_HIT      = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_OPENED   = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_RELEASED = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_DROPPED  = 3'd4;
  localparam logic [OUTC_W-1:0] OUT_ERROR    = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  object_id;
  } lhc_in_t;

  typedef struct packed {
    logic [OUTC_W-1:0]    outcome;
    logic [ID_W-1:0]      result_id;
    logic [PIN_OUT_W-1:0] pin_count;
    logic [CNT_W-1:0]     open_count;
    logic                 last;
  } lhc_out_t;

endpackage

`default_nettype wire

[rtl/lhc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/lru_handle_cache_with_pinning_unit.sv]
// Top level: LRU open-handle tracker with per-object pin counts.
//
// Usage:
//   A request (acquire, release or drop of one object) is taken on a clock edge
//   with start high and busy low; busy stays high while the request runs.
//   Results leave on out_data with out_strobe high for exactly one cycle; the
//   receiver cannot hold them off. The final result of a request has last set.
//   An acquire that misses at full capacity first emits one evicted result per
//   victim. capacity is written through cfg_we/cfg_data while idle.
// Flow:
//   release, drop, a hit on the newest object and errors found at decode end
//   in decode; any other hit relinks the object as newest; a miss evicts
//   while full, walking past pinned objects from the oldest, then links the
//   object as newest. With no unpinned victim the walk ends in an error.
//   One transaction at a time; the next can be accepted in the cycle the final
//   strobe is shown. The link walk reads one list node per cycle from the
//   link RAMs, which sets the eviction cost.
// Reset: all objects closed, list empty, capacity 64. The link RAMs need no
//   clearing pass; the pin RAM is masked by the open flags.
`default_nettype none

module lru_handle_cache_with_pinning_unit
  import lhc_pkg::*;
#(
  parameter int NUM_OBJECTS = NUM_OBJECTS_DEF,
  parameter int PIN_BITS    = PIN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lhc_in_t          in_data,
  output logic             out_strobe,
  output lhc_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IW    = $clog2(NUM_OBJECTS);
  localparam int PW    = $clog2(NUM_OBJECTS + 1);
  localparam int IDL_W = ID_W + 1;

  localparam logic [PW-1:0]       NIL      = PW'(NUM_OBJECTS);
  localparam logic [CAP_W-1:0]    CAP_MAX  = CAP_W'(NUM_OBJECTS);
  localparam logic [IDL_W-1:0]    ID_LIMIT = IDL_W'(NUM_OBJECTS);
  localparam logic [PIN_BITS-1:0] PIN_MAX  = {PIN_BITS{1'b1}};
  localparam logic [PIN_BITS-1:0] PIN_ONE  = PIN_BITS'(1);
  localparam logic [PW-1:0]       CNT_ONE  = PW'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_PUSH1 = 3'd4;
  localparam logic [2:0] S_PUSH2 = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [REQ_W-1:0]       req_r;
  logic [ID_W-1:0]        id_r;
  logic                   hit_r, hit_nxt;
  logic [PIN_BITS-1:0]    pin_r, pin_nxt;
  logic [IW-1:0]          cur_r, cur_nxt;
  logic [CAP_W-1:0]       cap_r;
  logic [NUM_OBJECTS-1:0] open_r, open_nxt;
  logic [PW-1:0]          newest_r, newest_nxt;
  logic [PW-1:0]          oldest_r, oldest_nxt;
  logic [PW-1:0]          total_r, total_nxt;
  logic                   out_strobe_r;
  lhc_out_t               out_data_r;

  logic                   emit, emit_last;
  logic [OUTC_W-1:0]      emit_outcome;
  logic [ID_W-1:0]        emit_id;
  logic [PIN_BITS-1:0]    emit_pin;

  logic [IW-1:0]          raddr;
  logic                   pins_we, newer_we, older_we;
  logic [IW-1:0]          pins_waddr, newer_waddr, older_waddr;
  logic [PIN_BITS-1:0]    pins_wdata, pins_rd;
  logic [PW-1:0]          newer_wdata, older_wdata, newer_rd, older_rd;

  logic                   unlink_en;
  logic [IW-1:0]          id_idx;
  logic [PW-1:0]          id_ptr;
  logic                   id_in_range;
  logic [PIN_BITS-1:0]    pin_eff, pin_step;
  logic [CAP_W-1:0]       eff_cap;
  logic                   cap_full;

  assign id_idx      = id_r[IW-1:0];
  assign id_ptr      = PW'(id_idx);
  assign id_in_range = IDL_W'(id_r) < ID_LIMIT;
  assign pin_eff     = open_r[id_idx] ? pins_rd : '0;
  // shared pin adder: +1 on acquire, -1 on release
  assign pin_step    = pin_eff + ((req_r == REQ_RELEASE) ? PIN_MAX : PIN_ONE);

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_r > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = cap_r;
    end
  end

  assign cap_full = CAP_W'(total_r) >= eff_cap;

  always_comb begin
    state_nxt    = state_r;
    hit_nxt      = hit_r;
    pin_nxt      = pin_r;
    cur_nxt      = cur_r;
    open_nxt     = open_r;
    newest_nxt   = newest_r;
    oldest_nxt   = oldest_r;
    total_nxt    = total_r;
    emit         = 1'b0;
    emit_last    = 1'b1;
    emit_outcome = OUT_ERROR;
    emit_id      = id_r;
    emit_pin     = '0;
    raddr        = id_idx;
    pins_we      = 1'b0;
    pins_waddr   = id_idx;
    pins_wdata   = pin_step;
    newer_we     = 1'b0;
    newer_waddr  = id_idx;
    newer_wdata  = NIL;
    older_we     = 1'b0;
    older_waddr  = id_idx;
    older_wdata  = newest_r;
    unlink_en    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        raddr = in_data.object_id[IW-1:0];
        if (start) begin
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        state_nxt = S_IDLE;
        if (!id_in_range) begin
          emit = 1'b1;
        end else begin
          case (req_r)
            REQ_ACQUIRE: begin
              if (open_r[id_idx]) begin
                if (pin_eff == PIN_MAX) begin
                  emit     = 1'b1;
                  emit_pin = pin_eff;
                end else if (newest_r == id_ptr) begin
                  pins_we      = 1'b1;
                  emit         = 1'b1;
                  emit_outcome = OUT_HIT;
                  emit_pin     = pin_step;
                end else begin
                  unlink_en = 1'b1;
                  pin_nxt   = pin_step;
                  hit_nxt   = 1'b1;
                  state_nxt = S_PUSH1;
                end
              end else begin
                pin_nxt   = PIN_ONE;
                hit_nxt   = 1'b0;
                state_nxt = S_CHECK;
              end
            end
            REQ_RELEASE: begin
              emit = 1'b1;
              if (pin_eff != '0) begin
                pins_we      = 1'b1;
                emit_outcome = OUT_RELEASED;
                emit_pin     = pin_step;
              end
            end
            REQ_DROP: begin
              emit = 1'b1;
              if (pin_eff != '0) begin
                emit_pin = pin_eff;
              end else begin
                emit_outcome = OUT_DROPPED;
                if (open_r[id_idx]) begin
                  unlink_en        = 1'b1;
                  open_nxt[id_idx] = 1'b0;
                  total_nxt        = total_r - CNT_ONE;
                end
              end
            end
            default: begin
              emit     = 1'b1;
              emit_pin = pin_eff;
            end
          endcase
        end
      end

      S_CHECK: begin
        if (cap_full) begin
          raddr     = oldest_r[IW-1:0];
          cur_nxt   = oldest_r[IW-1:0];
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_PUSH1;
        end
      end

      S_WALK: begin
        if (pins_rd != '0) begin
          if (newer_rd == NIL) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            raddr   = newer_rd[IW-1:0];
            cur_nxt = newer_rd[IW-1:0];
          end
        end else begin
          unlink_en       = 1'b1;
          open_nxt[cur_r] = 1'b0;
          total_nxt       = total_r - CNT_ONE;
          emit            = 1'b1;
          emit_last       = 1'b0;
          emit_outcome    = OUT_EVICTED;
          emit_id         = ID_W'(cur_r);
          state_nxt       = S_CHECK;
        end
      end

      S_PUSH1: begin
        older_we   = 1'b1;
        pins_we    = 1'b1;
        pins_wdata = pin_r;
        if (newest_r != NIL) begin
          newer_we    = 1'b1;
          newer_waddr = newest_r[IW-1:0];
          newer_wdata = id_ptr;
        end else begin
          oldest_nxt = id_ptr;
        end
        newest_nxt = id_ptr;
        if (!hit_r) begin
          open_nxt[id_idx] = 1'b1;
          total_nxt        = total_r + CNT_ONE;
        end
        state_nxt = S_PUSH2;
      end

      S_PUSH2: begin
        newer_we     = 1'b1;
        emit         = 1'b1;
        emit_outcome = hit_r ? OUT_HIT : OUT_OPENED;
        emit_pin     = pin_r;
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // remove the node whose links sit in the read registers
    if (unlink_en) begin
      if (older_rd != NIL) begin
        newer_we    = 1'b1;
        newer_waddr = older_rd[IW-1:0];
        newer_wdata = newer_rd;
      end else begin
        oldest_nxt = newer_rd;
      end
      if (newer_rd != NIL) begin
        older_we    = 1'b1;
        older_waddr = newer_rd[IW-1:0];
        older_wdata = older_rd;
      end else begin
        newest_nxt = older_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      open_r       <= '0;
      newest_r     <= NIL;
      oldest_r     <= NIL;
      total_r      <= '0;
      cap_r        <= CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      open_r       <= open_nxt;
      newest_r     <= newest_nxt;
      oldest_r     <= oldest_nxt;
      total_r      <= total_nxt;
      out_strobe_r <= emit;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    pin_r <= pin_nxt;
    cur_r <= cur_nxt;
    if (state_r == S_IDLE && start) begin
      req_r <= in_data.req_type;
      id_r  <= in_data.object_id;
    end
    if (emit) begin
      out_data_r.outcome    <= emit_outcome;
      out_data_r.result_id  <= emit_id;
      out_data_r.pin_count  <= PIN_OUT_W'(emit_pin);
      out_data_r.open_count <= CNT_W'(total_nxt);
      out_data_r.last       <= emit_last;
    end
  end

  lhc_ram #(.WIDTH(PIN_BITS), .DEPTH(NUM_OBJECTS)) u_pins (
    .clk   (clk),
    .we    (pins_we),
    .waddr (pins_waddr),
    .wdata (pins_wdata),
    .raddr (raddr),
    .rdata (pins_rd)
  );

  lhc_ram #(.WIDTH(PW), .DEPTH(NUM_OBJECTS)) u_newer (
    .clk   (clk),
    .we    (newer_we),
    .waddr (newer_waddr),
    .wdata (newer_wdata),
    .raddr (raddr),
    .rdata (newer_rd)
  );

  lhc_ram #(.WIDTH(PW), .DEPTH(NUM_OBJECTS)) u_older (
    .clk   (clk),
    .we    (older_we),
    .waddr (older_waddr),
    .wdata (older_wdata),
    .raddr (raddr),
    .rdata (older_rd)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

[rtl/lhc_chk.sv]
// Port-level checker for the LRU handle cache, bound to the top level.
`default_nettype none

module lhc_chk
  import lhc_pkg::*;
#(
  parameter int NUM_OBJECTS = NUM_OBJECTS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input lhc_out_t out_data
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_OBJECTS);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_strobe)
    else $error("not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.last == !busy))
    else $error("final result and busy disagree");

  a_evict_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.outcome == OUT_EVICTED |->
      !out_data.last && out_data.pin_count == '0)
    else $error("bad eviction result");

  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.open_count <= CNT_MAX)
    else $error("open count above object count");

endmodule

bind lru_handle_cache_with_pinning_unit lhc_chk #(.NUM_OBJECTS(NUM_OBJECTS)) u_lhc_chk (.*);

`default_nettype wire
